>>> rtl/core/wfp_pkg.sv
// Shared types and constants of the wireframe fit projector.
// No dependencies; imported by every module of the block.
package wfp_pkg;

    localparam int VDEPTH    = 1024;
    localparam int ADDR_W    = $clog2(VDEPTH);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int FRAC      = 16;
    localparam int COORD_W   = 32;
    localparam int PROJ_W    = 34;
    localparam int EXT_W     = PROJ_W + 1;
    localparam int SIZE_W    = 11;
    localparam int MARGIN_W  = 8;
    localparam int SCALE_W   = 32;
    localparam int DIVD_W    = SIZE_W + FRAC + 16;
    localparam int SCR_W     = 10;
    localparam int PMUL_W    = 51;
    localparam int K_SHIFT   = 16;
    localparam int ISO_K     = 56756;
    // extents below 0.0001 are treated as one unit
    localparam int EXT_SMALL = (2 ** FRAC + 9999) / 10000;
    localparam int SAT_BIT   = FRAC + 27;
    localparam int HALF_SH   = FRAC + 15;
    localparam int SCR_SH    = FRAC + 16;
    localparam int MAG_W     = 36;
    localparam int CHUNK_W   = MAG_W / 2;
    localparam int ACC_W     = MAG_W + SCALE_W;
    localparam int TOT_W     = 47;

    typedef enum logic [1:0] {
        ACT_VERTEX = 2'd0,
        ACT_FIT    = 2'd1,
        ACT_EDGE   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_EDGE     = 2'd0,
        ST_FIT_DONE = 2'd1,
        ST_FIT_FAIL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_MARGIN = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_VTX_BOX, S_FIT_CTR, S_FIT_DX, S_FIT_DY,
        S_E_RD, S_E_PRJ, S_E_DIF, S_E_XLO, S_E_XHI, S_E_XFN,
        S_E_YLO, S_E_YHI, S_E_YFN, S_OUT
    } state_t;

    typedef struct packed {
        logic    load_in;
        logic    vtx_write;
        logic    proj_mem;
        logic    proj_mul;
        logic    box_update;
        logic    fit_center;
        logic    div_start;
        logic    div_axis;
        logic    scale_x_save;
        logic    scale_save;
        logic    rd_en;
        logic    pt;
        logic    diff;
        logic    scr_lo;
        logic    scr_hi;
        logic    scr_fin;
        logic    axis;
        logic    out_load;
        status_t out_status;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    count_zero;
        logic    count_full;
        logic    edge_ok;
        logic    div_done;
    } dp_stat_t;

endpackage

>>> rtl/core/wfp_div.sv
// Radix-2 restoring divider for the fit scale, one quotient bit per cycle.
// Depends on wfp_pkg.
module wfp_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [wfp_pkg::DIVD_W-1:0]    dividend,
    input  logic [wfp_pkg::EXT_W-1:0]     divisor,
    output logic                          done,
    output logic [wfp_pkg::SCALE_W-1:0]   quotient
);
    import wfp_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic [EXT_W-1:0]  rem_reg, rem_next;
    logic [EXT_W-1:0]  div_reg;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg, done_reg;
    logic [EXT_W:0]    shifted, trial;
    logic              ge;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DIVD_W-1]};
        trial    = shifted - {1'b0, div_reg};
        ge       = shifted >= {1'b0, div_reg};
        rem_next = ge ? trial[EXT_W-1:0] : shifted[EXT_W-1:0];
        quo_next = {quo_reg[DIVD_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(DIVD_W);
        end else if (busy_reg) begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = (quo_reg[DIVD_W-1:SCALE_W] != '0) ? '1 : quo_reg[SCALE_W-1:0];

endmodule

>>> rtl/core/wfp_datapath.sv
// Datapath: vertex store, projection, bounding box, fit and screen mapping.
// Depends on wfp_pkg and wfp_div.
module wfp_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic [1:0]                     cfg_addr,
    input  logic [wfp_pkg::SIZE_W-1:0]     cfg_data,
    input  logic [1:0]                     s_action,
    input  logic [wfp_pkg::COORD_W-1:0]    s_vertex_x,
    input  logic [wfp_pkg::COORD_W-1:0]    s_vertex_y,
    input  logic [wfp_pkg::COORD_W-1:0]    s_vertex_z,
    input  logic [wfp_pkg::ADDR_W-1:0]     s_edge_start,
    input  logic [wfp_pkg::ADDR_W-1:0]     s_edge_end,
    input  wfp_pkg::dp_cmd_t               cmd,
    output wfp_pkg::dp_stat_t              stat,
    output logic [1:0]                     m_status,
    output logic [wfp_pkg::SCR_W-1:0]      m_screen_x1,
    output logic [wfp_pkg::SCR_W-1:0]      m_screen_y1,
    output logic [wfp_pkg::SCR_W-1:0]      m_screen_x2,
    output logic [wfp_pkg::SCR_W-1:0]      m_screen_y2
);
    import wfp_pkg::*;

    localparam logic signed [17:0] ISO_K_S = 18'(ISO_K);

    // configuration
    logic [SIZE_W-1:0]   sw_reg, sh_reg;
    logic [MARGIN_W-1:0] bm_reg;

    // latched input beat
    action_t             act_reg;
    logic [COORD_W-1:0]  in_x_reg, in_y_reg, in_z_reg;
    logic [ADDR_W-1:0]   ea_reg, eb_reg;

    logic [CNT_W-1:0]    count_reg;
    logic [3*COORD_W-1:0] vmem [VDEPTH];
    logic [3*COORD_W-1:0] rdata_reg;

    logic signed [PROJ_W-1:0] minx_reg, maxx_reg, miny_reg, maxy_reg;
    logic signed [PROJ_W-1:0] cx_reg, cy_reg;
    logic [SCALE_W-1:0]       scale_reg, sx_reg;

    logic signed [PMUL_W-1:0] pmul_reg, pmul_next;
    logic signed [PROJ_W-1:0] py_reg, py_next, px_w;
    logic signed [EXT_W-1:0]  dx_reg, dy_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [SCR_W-1:0]         x1_reg, y1_reg, x2_reg, y2_reg;
    logic [1:0]               ms_reg;
    logic [SCR_W-1:0]         mx1_reg, my1_reg, mx2_reg, my2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg <= SIZE_W'(256);
            sh_reg <= SIZE_W'(256);
            bm_reg <= MARGIN_W'(20);
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_WIDTH:  sw_reg <= cfg_data;
                CFG_HEIGHT: sh_reg <= cfg_data;
                CFG_MARGIN: bm_reg <= cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            act_reg  <= action_t'(s_action);
            in_x_reg <= s_vertex_x;
            in_y_reg <= s_vertex_y;
            in_z_reg <= s_vertex_z;
            ea_reg   <= s_edge_start;
            eb_reg   <= s_edge_end;
        end
    end

    // vertex store
    always_ff @(posedge aclk) begin
        if (cmd.vtx_write)
            vmem[count_reg[ADDR_W-1:0]] <= {in_x_reg, in_y_reg, in_z_reg};
        if (cmd.rd_en)
            rdata_reg <= vmem[cmd.pt ? eb_reg : ea_reg];
    end

    // isometric projection
    logic [COORD_W-1:0]     src_x, src_y, src_z;
    logic signed [COORD_W:0] dxz, sxz;

    always_comb begin
        src_x     = cmd.proj_mem ? rdata_reg[3*COORD_W-1:2*COORD_W] : in_x_reg;
        src_y     = cmd.proj_mem ? rdata_reg[2*COORD_W-1:COORD_W]   : in_y_reg;
        src_z     = cmd.proj_mem ? rdata_reg[COORD_W-1:0]           : in_z_reg;
        dxz       = $signed({src_x[COORD_W-1], src_x}) - $signed({src_z[COORD_W-1], src_z});
        sxz       = $signed({src_x[COORD_W-1], src_x}) + $signed({src_z[COORD_W-1], src_z});
        pmul_next = dxz * ISO_K_S;
        py_next   = $signed({{2{src_y[COORD_W-1]}}, src_y}) + $signed({sxz[COORD_W], sxz[COORD_W:1]});
        px_w      = pmul_reg[K_SHIFT+PROJ_W-1:K_SHIFT];
    end

    always_ff @(posedge aclk) begin
        if (cmd.proj_mul) begin
            pmul_reg <= pmul_next;
            py_reg   <= py_next;
        end
        if (cmd.diff) begin
            dx_reg <= $signed({px_w[PROJ_W-1], px_w}) - $signed({cx_reg[PROJ_W-1], cx_reg});
            dy_reg <= $signed({py_reg[PROJ_W-1], py_reg}) - $signed({cy_reg[PROJ_W-1], cy_reg});
        end
    end

    // fit: centers, extents, divider
    logic signed [EXT_W-1:0] sumx, sumy, extx, exty;
    logic [EXT_W-1:0]        ext_sel, divisor;
    logic signed [SIZE_W+1:0] avail_full;
    logic [SIZE_W-1:0]       avail, size_sel;
    logic [DIVD_W-1:0]       dividend;
    logic [SCALE_W-1:0]      quotient;
    logic                    div_done;

    always_comb begin
        sumx       = $signed({minx_reg[PROJ_W-1], minx_reg}) + $signed({maxx_reg[PROJ_W-1], maxx_reg});
        sumy       = $signed({miny_reg[PROJ_W-1], miny_reg}) + $signed({maxy_reg[PROJ_W-1], maxy_reg});
        extx       = $signed({maxx_reg[PROJ_W-1], maxx_reg}) - $signed({minx_reg[PROJ_W-1], minx_reg});
        exty       = $signed({maxy_reg[PROJ_W-1], maxy_reg}) - $signed({miny_reg[PROJ_W-1], miny_reg});
        ext_sel    = cmd.div_axis ? exty : extx;
        divisor    = (ext_sel < EXT_W'(EXT_SMALL)) ? (EXT_W'(1) << FRAC) : ext_sel;
        size_sel   = cmd.div_axis ? sh_reg : sw_reg;
        avail_full = $signed({2'b00, size_sel}) - $signed({4'b0000, bm_reg, 1'b0});
        avail      = avail_full[SIZE_W+1] ? '0 : avail_full[SIZE_W-1:0];
        dividend   = {avail, (DIVD_W-SIZE_W)'(0)};
    end

    wfp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            minx_reg  <= '0;
            maxx_reg  <= '0;
            miny_reg  <= '0;
            maxy_reg  <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            scale_reg <= '0;
        end else begin
            if (cmd.box_update) begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == '0) begin
                    minx_reg <= px_w;
                    maxx_reg <= px_w;
                    miny_reg <= py_reg;
                    maxy_reg <= py_reg;
                end else begin
                    if (px_w < minx_reg)   minx_reg <= px_w;
                    if (px_w > maxx_reg)   maxx_reg <= px_w;
                    if (py_reg < miny_reg) miny_reg <= py_reg;
                    if (py_reg > maxy_reg) maxy_reg <= py_reg;
                end
            end
            if (cmd.fit_center) begin
                cx_reg <= sumx[EXT_W-1:1];
                cy_reg <= sumy[EXT_W-1:1];
            end
            if (cmd.scale_save)
                scale_reg <= (quotient < sx_reg) ? quotient : sx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scale_x_save)
            sx_reg <= quotient;
    end

    // screen mapping: |d| * scale in two halves, then offset and clamp
    logic signed [EXT_W-1:0] d_sel;
    logic                    d_neg, neg_out, sat;
    logic [MAG_W-1:0]        mag;
    logic [CHUNK_W-1:0]      chunk;
    logic [CHUNK_W+SCALE_W-1:0] pp;
    logic [SIZE_W-1:0]       scr_size, hi_full;
    logic [SCR_W-1:0]        hi_lim, scr_val;
    logic signed [TOT_W-1:0] base, total;
    logic [13:0]             q;

    always_comb begin
        d_sel    = cmd.axis ? dy_reg : dx_reg;
        d_neg    = d_sel[EXT_W-1];
        mag      = d_neg ? MAG_W'(-$signed({d_sel[EXT_W-1], d_sel}))
                         : MAG_W'($signed({d_sel[EXT_W-1], d_sel}));
        chunk    = cmd.scr_hi ? mag[MAG_W-1:CHUNK_W] : mag[CHUNK_W-1:0];
        pp       = chunk * scale_reg;
        // rows run opposite to y
        neg_out  = cmd.axis ? !d_neg : d_neg;
        scr_size = cmd.axis ? sh_reg : sw_reg;
        hi_full  = scr_size - 1'b1;
        if (scr_size == '0)
            hi_lim = '0;
        else if (hi_full > SIZE_W'(2 ** SCR_W - 1))
            hi_lim = '1;
        else
            hi_lim = hi_full[SCR_W-1:0];
        sat   = acc_reg > (ACC_W'(1) << SAT_BIT);
        base  = $signed(TOT_W'(scr_size) << HALF_SH);
        total = neg_out ? base - $signed(TOT_W'(acc_reg[SAT_BIT:0]))
                        : base + $signed(TOT_W'(acc_reg[SAT_BIT:0]));
        q     = total[SCR_SH +: 14];
        if (sat)
            scr_val = neg_out ? '0 : hi_lim;
        else if (total[TOT_W-1])
            scr_val = '0;
        else if (q > 14'(hi_lim))
            scr_val = hi_lim;
        else
            scr_val = q[SCR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.scr_lo)
            acc_reg <= ACC_W'(pp);
        else if (cmd.scr_hi)
            acc_reg <= acc_reg + (ACC_W'(pp) << CHUNK_W);
        if (cmd.scr_fin) begin
            unique case ({cmd.pt, cmd.axis})
                2'b00: x1_reg <= scr_val;
                2'b01: y1_reg <= scr_val;
                2'b10: x2_reg <= scr_val;
                2'b11: y2_reg <= scr_val;
                default: ;
            endcase
        end
        if (cmd.out_load) begin
            ms_reg <= cmd.out_status;
            if (cmd.out_status == ST_EDGE) begin
                mx1_reg <= x1_reg;
                my1_reg <= y1_reg;
                mx2_reg <= x2_reg;
                my2_reg <= y2_reg;
            end else begin
                mx1_reg <= '0;
                my1_reg <= '0;
                mx2_reg <= '0;
                my2_reg <= '0;
            end
        end
    end

    always_comb begin
        stat.action     = act_reg;
        stat.count_zero = count_reg == '0;
        stat.count_full = count_reg >= CNT_W'(VDEPTH);
        stat.edge_ok    = (ea_reg != eb_reg) && ({1'b0, ea_reg} < count_reg)
                          && ({1'b0, eb_reg} < count_reg);
        stat.div_done   = div_done;
    end

    assign m_status    = ms_reg;
    assign m_screen_x1 = mx1_reg;
    assign m_screen_y1 = my1_reg;
    assign m_screen_x2 = mx2_reg;
    assign m_screen_y2 = my2_reg;

endmodule

>>> rtl/core/wfp_ctrl.sv
// Controller state machine: sequences vertex, fit and edge work and the
// result handshake. Depends on wfp_pkg.
module wfp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  wfp_pkg::dp_stat_t  stat,
    output wfp_pkg::dp_cmd_t   cmd
);
    import wfp_pkg::*;

    state_t  state_reg, state_next;
    logic    pt_reg, pt_next;
    status_t ost_reg, ost_next;
    logic    m_valid_reg, m_valid_next;
    logic    out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        pt_next    = pt_reg;
        ost_next   = ost_reg;
        unique case (state_reg)
            S_IDLE: if (s_valid) state_next = S_DISPATCH;
            S_DISPATCH: begin
                pt_next = 1'b0;
                unique case (stat.action)
                    ACT_VERTEX: state_next = stat.count_full ? S_IDLE : S_VTX_BOX;
                    ACT_FIT: begin
                        if (stat.count_zero) begin
                            ost_next   = ST_FIT_FAIL;
                            state_next = S_OUT;
                        end else begin
                            state_next = S_FIT_CTR;
                        end
                    end
                    ACT_EDGE: state_next = stat.edge_ok ? S_E_RD : S_IDLE;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_VTX_BOX: state_next = S_IDLE;
            S_FIT_CTR: state_next = S_FIT_DX;
            S_FIT_DX:  if (stat.div_done) state_next = S_FIT_DY;
            S_FIT_DY: begin
                if (stat.div_done) begin
                    ost_next   = ST_FIT_DONE;
                    state_next = S_OUT;
                end
            end
            S_E_RD:  state_next = S_E_PRJ;
            S_E_PRJ: state_next = S_E_DIF;
            S_E_DIF: state_next = S_E_XLO;
            S_E_XLO: state_next = S_E_XHI;
            S_E_XHI: state_next = S_E_XFN;
            S_E_XFN: state_next = S_E_YLO;
            S_E_YLO: state_next = S_E_YHI;
            S_E_YHI: state_next = S_E_YFN;
            S_E_YFN: begin
                if (pt_reg) begin
                    ost_next   = ST_EDGE;
                    state_next = S_OUT;
                end else begin
                    pt_next    = 1'b1;
                    state_next = S_E_RD;
                end
            end
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.pt         = pt_reg;
        cmd.out_status = ost_reg;
        s_ready        = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            S_DISPATCH: begin
                if (stat.action == ACT_VERTEX && !stat.count_full) begin
                    cmd.vtx_write = 1'b1;
                    cmd.proj_mul  = 1'b1;
                end
            end
            S_VTX_BOX: cmd.box_update = 1'b1;
            S_FIT_CTR: begin
                cmd.fit_center = 1'b1;
                cmd.div_start  = 1'b1;
            end
            S_FIT_DX: begin
                cmd.scale_x_save = stat.div_done;
                cmd.div_start    = stat.div_done;
                cmd.div_axis     = 1'b1;
            end
            S_FIT_DY: cmd.scale_save = stat.div_done;
            S_E_RD:   cmd.rd_en = 1'b1;
            S_E_PRJ: begin
                cmd.proj_mem = 1'b1;
                cmd.proj_mul = 1'b1;
            end
            S_E_DIF: cmd.diff = 1'b1;
            S_E_XLO: cmd.scr_lo = 1'b1;
            S_E_XHI: cmd.scr_hi = 1'b1;
            S_E_XFN: cmd.scr_fin = 1'b1;
            S_E_YLO: begin
                cmd.scr_lo = 1'b1;
                cmd.axis   = 1'b1;
            end
            S_E_YHI: begin
                cmd.scr_hi = 1'b1;
                cmd.axis   = 1'b1;
            end
            S_E_YFN: begin
                cmd.scr_fin = 1'b1;
                cmd.axis    = 1'b1;
            end
            S_OUT:   cmd.out_load = out_free;
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.out_load)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pt_reg      <= 1'b0;
            ost_reg     <= ST_EDGE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pt_reg      <= pt_next;
            ost_reg     <= ost_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> rtl/core/wireframe_fit_projector.sv
// Wireframe fit projector: stores vertices, tracks the isometric bounding
// box, fits it to the screen and maps edges to screen coordinates.
// A vertex beat is stored, projected and added to the bounding box. A fit
// runs the radix-2 divider for 43 steps for each axis in turn. An edge
// does, per endpoint, one store read, one projection multiply, and two
// 18x32 partial products for each screen axis. A result waits in the output
// register while the next beat is taken. Config writes are accepted every
// cycle (cfg_ready is tied high) and are meant for when the block is idle.
// Depends on wfp_pkg, wfp_ctrl, wfp_datapath and wfp_div.
module wireframe_fit_projector (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_addr,
    input  logic [wfp_pkg::SIZE_W-1:0]     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_action,
    input  logic [wfp_pkg::COORD_W-1:0]    s_vertex_x,
    input  logic [wfp_pkg::COORD_W-1:0]    s_vertex_y,
    input  logic [wfp_pkg::COORD_W-1:0]    s_vertex_z,
    input  logic [wfp_pkg::ADDR_W-1:0]     s_edge_start,
    input  logic [wfp_pkg::ADDR_W-1:0]     s_edge_end,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [wfp_pkg::SCR_W-1:0]      m_screen_x1,
    output logic [wfp_pkg::SCR_W-1:0]      m_screen_y1,
    output logic [wfp_pkg::SCR_W-1:0]      m_screen_x2,
    output logic [wfp_pkg::SCR_W-1:0]      m_screen_y2
);
    import wfp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    wfp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    wfp_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .s_action     (s_action),
        .s_vertex_x   (s_vertex_x),
        .s_vertex_y   (s_vertex_y),
        .s_vertex_z   (s_vertex_z),
        .s_edge_start (s_edge_start),
        .s_edge_end   (s_edge_end),
        .cmd          (cmd),
        .stat         (stat),
        .m_status     (m_status),
        .m_screen_x1  (m_screen_x1),
        .m_screen_y1  (m_screen_y1),
        .m_screen_x2  (m_screen_x2),
        .m_screen_y2  (m_screen_y2)
    );

endmodule
